>>> hw/rtl/tsc_pkg.sv
package tsc_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic        record_kind;
    logic [31:0] paragraph_index;
    logic [31:0] paragraph_word_count;
    logic [31:0] paragraph_offset;
    logic [31:0] chars_with_spaces;
    logic [31:0] chars_without_spaces;
    logic [31:0] total_words;
    logic [31:0] total_sentences;
    logic [31:0] total_paragraphs;
    logic [31:0] read_time_minutes;
    logic        last_of_run;
  } out_t;

  // One queue entry: everything a byte leaves for the back end to report
  typedef struct packed {
    logic        has_para;
    logic [31:0] para_index;
    logic [31:0] para_words;
    logic [31:0] para_offset;
    logic        has_sum;
    logic [31:0] with_spaces;
    logic [31:0] without_spaces;
    logic [31:0] words;
    logic [31:0] sentences;
    logic [31:0] paragraphs;
  } ev_t;

  localparam logic KIND_PARAGRAPH = 1'b0;
  localparam logic KIND_SUMMARY   = 1'b1;

  localparam logic CFG_READING_SPEED   = 1'b0;
  localparam logic CFG_PARAGRAPH_LIMIT = 1'b1;

  localparam logic [15:0] READING_SPEED_RESET   = 16'd250;
  localparam logic [15:0] PARAGRAPH_LIMIT_RESET = 16'd150;

  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_APOSTROPHE = 8'h27;
  localparam logic [7:0] CH_HYPHEN     = 8'h2D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_PERIOD     = 8'h2E;
  localparam logic [7:0] CH_EXCLAIM    = 8'h21;
  localparam logic [7:0] CH_QUESTION   = 8'h3F;

  localparam int QUEUE_DEPTH = 2;

endpackage

>>> hw/rtl/tsc_front.sv
module tsc_front
  import tsc_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_t                    in_data,
  input  logic [15:0]            para_limit,
  output logic                   ev_valid,
  input  logic                   ev_ready,
  output ev_t                    ev,
  output logic [COUNT_WIDTH-1:0] ev_words
);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (&v) ? v : v + cnt_t'(1);
  endfunction

  function automatic logic [31:0] low32(input cnt_t v);
    logic [63:0] t;
    t = 64'(v);
    return t[31:0];
  endfunction

  logic [1:0] skip_r, skip_nxt;
  logic       tok_r, tok_nxt;
  logic       psend_r, psend_nxt;
  logic       phw_r, phw_nxt;
  cnt_t       words_r, words_nxt;
  cnt_t       pwords_r, pwords_nxt;
  cnt_t       pnum_r, pnum_nxt;
  cnt_t       pstart_r, pstart_nxt;
  cnt_t       pos_r, pos_nxt;
  cnt_t       with_r, with_nxt;
  cnt_t       without_r, without_nxt;
  cnt_t       sent_r, sent_nxt;
  cnt_t       ptot_r, ptot_nxt;

  logic [7:0] b;
  logic       fin, accept;
  logic       ws, alnum, wordc, send;
  cnt_t       limit_ext;

  assign in_ready  = ev_ready;
  assign accept    = in_valid && in_ready;
  assign b         = in_data.text_byte;
  assign fin       = in_data.final_byte;
  assign limit_ext = cnt_t'(para_limit);

  assign ws    = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  assign alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
                 (b >= 8'h61 && b <= 8'h7A);
  assign wordc = b[7] || alnum || (b == CH_APOSTROPHE) || (b == CH_HYPHEN);
  assign send  = (b == CH_PERIOD) || (b == CH_EXCLAIM) || (b == CH_QUESTION);

  always_comb begin
    skip_nxt    = skip_r;
    tok_nxt     = tok_r;
    psend_nxt   = psend_r;
    phw_nxt     = phw_r;
    words_nxt   = words_r;
    pwords_nxt  = pwords_r;
    pnum_nxt    = pnum_r;
    pstart_nxt  = pstart_r;
    pos_nxt     = pos_r;
    with_nxt    = with_r;
    without_nxt = without_r;
    sent_nxt    = sent_r;
    ptot_nxt    = ptot_r;
    ev          = '0;
    ev_words    = words_r;

    if (b[7:6] != 2'b10) begin
      with_nxt = sat_inc(with_r);
    end

    if (skip_r != 2'd0) begin
      skip_nxt = skip_r - 2'd1;
    end else begin
      if (b[7:5] == 3'b110) begin
        skip_nxt = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        skip_nxt = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        skip_nxt = 2'd3;
      end
      if (!ws) begin
        without_nxt = sat_inc(without_r);
      end
      if (wordc) begin
        tok_nxt = 1'b1;
      end else if (tok_nxt) begin
        words_nxt  = sat_inc(words_nxt);
        pwords_nxt = sat_inc(pwords_nxt);
        phw_nxt    = 1'b1;
        tok_nxt    = 1'b0;
      end
      if (send && !psend_r) begin
        sent_nxt = sat_inc(sent_r);
      end
      psend_nxt = send;
      if (b == CH_NEWLINE) begin
        if (phw_nxt) begin
          ptot_nxt = sat_inc(ptot_nxt);
          if (pwords_nxt >= limit_ext) begin
            ev.has_para    = 1'b1;
            ev.para_index  = low32(pnum_nxt);
            ev.para_words  = low32(pwords_nxt);
            ev.para_offset = low32(pstart_nxt);
          end
          pnum_nxt   = sat_inc(pnum_nxt);
          pwords_nxt = '0;
          phw_nxt    = 1'b0;
        end
        pstart_nxt = sat_inc(pos_r);
      end
      pos_nxt = sat_inc(pos_r);
    end

    if (fin) begin
      // close the open word and paragraph, then report totals
      if (tok_nxt) begin
        words_nxt  = sat_inc(words_nxt);
        pwords_nxt = sat_inc(pwords_nxt);
        phw_nxt    = 1'b1;
        tok_nxt    = 1'b0;
      end
      if (phw_nxt) begin
        ptot_nxt = sat_inc(ptot_nxt);
        if (pwords_nxt >= limit_ext) begin
          ev.has_para    = 1'b1;
          ev.para_index  = low32(pnum_nxt);
          ev.para_words  = low32(pwords_nxt);
          ev.para_offset = low32(pstart_nxt);
        end
      end
      ev.has_sum        = 1'b1;
      ev.with_spaces    = low32(with_nxt);
      ev.without_spaces = low32(without_nxt);
      ev.words          = low32(words_nxt);
      ev.sentences      = low32(sent_nxt);
      ev.paragraphs     = low32(ptot_nxt);
      ev_words          = words_nxt;

      // back to the start-of-text state
      skip_nxt    = 2'd0;
      tok_nxt     = 1'b0;
      psend_nxt   = 1'b0;
      phw_nxt     = 1'b0;
      words_nxt   = '0;
      pwords_nxt  = '0;
      pnum_nxt    = cnt_t'(1);
      pstart_nxt  = '0;
      pos_nxt     = '0;
      with_nxt    = '0;
      without_nxt = '0;
      sent_nxt    = '0;
      ptot_nxt    = '0;
    end
  end

  assign ev_valid = accept && (ev.has_para || ev.has_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r    <= 2'd0;
      tok_r     <= 1'b0;
      psend_r   <= 1'b0;
      phw_r     <= 1'b0;
      words_r   <= '0;
      pwords_r  <= '0;
      pnum_r    <= cnt_t'(1);
      pstart_r  <= '0;
      pos_r     <= '0;
      with_r    <= '0;
      without_r <= '0;
      sent_r    <= '0;
      ptot_r    <= '0;
    end else if (accept) begin
      skip_r    <= skip_nxt;
      tok_r     <= tok_nxt;
      psend_r   <= psend_nxt;
      phw_r     <= phw_nxt;
      words_r   <= words_nxt;
      pwords_r  <= pwords_nxt;
      pnum_r    <= pnum_nxt;
      pstart_r  <= pstart_nxt;
      pos_r     <= pos_nxt;
      with_r    <= with_nxt;
      without_r <= without_nxt;
      sent_r    <= sent_nxt;
      ptot_r    <= ptot_nxt;
    end
  end

endmodule

>>> hw/rtl/tsc_queue.sv
module tsc_queue
  import tsc_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  ev_t                    push_ev,
  input  logic [COUNT_WIDTH-1:0] push_words,
  output logic                   pop_valid,
  input  logic                   pop_ready,
  output ev_t                    pop_ev,
  output logic [COUNT_WIDTH-1:0] pop_words
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ev_t                    ev_mem_r    [QUEUE_DEPTH];
  logic [COUNT_WIDTH-1:0] words_mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]       fill_r;
  logic                   push, pop;

  assign push_ready = fill_r != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = fill_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_ev     = ev_mem_r[rd_ptr_r];
  assign pop_words  = words_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ev_mem_r[wr_ptr_r]    <= push_ev;
      words_mem_r[wr_ptr_r] <= push_words;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + CNT_W'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - CNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/tsc_back.sv
module tsc_back
  import tsc_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   ev_valid,
  output logic                   ev_ready,
  input  ev_t                    ev,
  input  logic [COUNT_WIDTH-1:0] ev_words,
  input  logic [15:0]            reading_speed,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_t                   out_data
);

  localparam int STEP_W = $clog2(COUNT_WIDTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_PARA = 4'b0100,
    ST_SUM  = 4'b1000
  } back_state_t;

  back_state_t            state_r, state_nxt;
  ev_t                    ent_r, ent_nxt;
  logic [COUNT_WIDTH-1:0] quo_r, quo_nxt;
  logic [15:0]            rem_r, rem_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_t                   out_r, out_nxt;

  logic [15:0]            divisor;
  logic [16:0]            trial, diff;
  logic                   fits, out_free;
  logic [COUNT_WIDTH-1:0] minutes_full;
  logic [63:0]            minutes_64;

  assign divisor      = (reading_speed == 16'd0) ? 16'd1 : reading_speed;
  assign trial        = {rem_r, quo_r[COUNT_WIDTH-1]};
  assign diff         = trial - {1'b0, divisor};
  assign fits         = trial >= {1'b0, divisor};
  assign minutes_full = quo_r + COUNT_WIDTH'(rem_r != 16'd0);
  assign minutes_64   = 64'(minutes_full);
  assign out_free     = !out_valid_r || out_ready;
  assign ev_ready     = state_r == ST_IDLE;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

  always_comb begin
    state_nxt     = state_r;
    ent_nxt       = ent_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    unique case (state_r)
      ST_IDLE: begin
        if (ev_valid) begin
          ent_nxt  = ev;
          quo_nxt  = ev_words;
          rem_nxt  = '0;
          step_nxt = STEP_W'(COUNT_WIDTH);
          state_nxt = ev.has_sum ? ST_DIV : ST_PARA;
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle, restoring
        quo_nxt  = {quo_r[COUNT_WIDTH-2:0], fits};
        rem_nxt  = fits ? diff[15:0] : trial[15:0];
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          state_nxt = ent_r.has_para ? ST_PARA : ST_SUM;
        end
      end
      ST_PARA: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_nxt                      = '0;
          out_nxt.record_kind          = KIND_PARAGRAPH;
          out_nxt.paragraph_index      = ent_r.para_index;
          out_nxt.paragraph_word_count = ent_r.para_words;
          out_nxt.paragraph_offset     = ent_r.para_offset;
          out_nxt.last_of_run          = !ent_r.has_sum;
          state_nxt = ent_r.has_sum ? ST_SUM : ST_IDLE;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_nxt                      = '0;
          out_nxt.record_kind          = KIND_SUMMARY;
          out_nxt.chars_with_spaces    = ent_r.with_spaces;
          out_nxt.chars_without_spaces = ent_r.without_spaces;
          out_nxt.total_words          = ent_r.words;
          out_nxt.total_sentences      = ent_r.sentences;
          out_nxt.total_paragraphs     = ent_r.paragraphs;
          out_nxt.read_time_minutes    = minutes_64[31:0];
          out_nxt.last_of_run          = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    out_r <= out_nxt;
  end

endmodule

>>> hw/rtl/text_statistics_counter_unit.sv
// Text statistics over a UTF-8 byte stream.
//
// in_*  : one text byte per transfer, final_byte marks the last byte of a text.
// out_* : result records. A newline that closes a paragraph of at least
//         long_paragraph_limit words yields a paragraph record; the final byte
//         yields an optional paragraph record followed by the summary.
//         last_of_run is set on the last record a byte produces.
// cfg_* : index 0 reading_speed, index 1 long_paragraph_limit; always ready.
//
// Bytes that produce no record are taken one per cycle while the queue has
// room. A byte with records goes into a two-entry queue; for a summary the
// back end runs the restoring divide for the reading time, then moves each
// record into the output register, and it takes the next entry only once
// it has sent every record of the last one. A stalled receiver holds the
// output register; the front keeps taking bytes until the queue fills.
// Reset (synchronous, rst_n low) clears all counters and loads the register
// defaults 250 and 150. After each summary the counters restart.
module text_statistics_counter_unit
  import tsc_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]            speed_r, limit_r;
  logic                   fe_valid, fe_ready, be_valid, be_ready;
  ev_t                    fe_ev, be_ev;
  logic [COUNT_WIDTH-1:0] fe_words, be_words;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= READING_SPEED_RESET;
      limit_r <= PARAGRAPH_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_READING_SPEED:   speed_r <= cfg_data;
        CFG_PARAGRAPH_LIMIT: limit_r <= cfg_data;
        default:             speed_r <= speed_r;
      endcase
    end
  end

  tsc_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .para_limit (limit_r),
    .ev_valid   (fe_valid),
    .ev_ready   (fe_ready),
    .ev         (fe_ev),
    .ev_words   (fe_words)
  );

  tsc_queue #(.COUNT_WIDTH(COUNT_WIDTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_ev    (fe_ev),
    .push_words (fe_words),
    .pop_valid  (be_valid),
    .pop_ready  (be_ready),
    .pop_ev     (be_ev),
    .pop_words  (be_words)
  );

  tsc_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .ev_valid      (be_valid),
    .ev_ready      (be_ready),
    .ev            (be_ev),
    .ev_words      (be_words),
    .reading_speed (speed_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule
